[design/assert_macros.svh]
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[design/swts_pkg.sv]
// Shared types and constants for the sliding-window temperature statistics block.
// No dependencies.
`default_nettype none

package swts_pkg;

   // Sample and result field widths
   localparam int DATA_W     = 16;
   localparam int HELD_W     = 4;
   // Default window depth
   localparam int WINDOW_DEF = 10;

   // Divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

[design/sliding_window_temperature_stats.sv]
// Each request steps through update, scan and finish; the response waits on the serial divider
// and on a free response register.
// One request in flight; the next is taken once the result is registered, while that result
// may still wait on the response side.
// Reset: synchronous, clears slot, fill count and running sum; ring contents stay undefined.
`default_nettype none

module sliding_window_temperature_stats #(
   parameter int WINDOW = swts_pkg::WINDOW_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [swts_pkg::DATA_W-1:0] req_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [swts_pkg::DATA_W-1:0]     rsp_mean,
   output logic signed [swts_pkg::DATA_W-1:0]     rsp_minimum,
   output logic signed [swts_pkg::DATA_W-1:0]     rsp_maximum,
   output logic [swts_pkg::HELD_W-1:0]            rsp_held
);
   import swts_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = DATA_W + $clog2(WINDOW);

   typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_SCAN, S_FINISH} state_type;

   state_type                state_ff, state_in;
   logic signed [DATA_W-1:0] sample_ff, sample_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                     issue_ff, issue_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic                     first_ff, first_in;
   logic signed [DATA_W-1:0] lo_ff, lo_in;
   logic signed [DATA_W-1:0] hi_ff, hi_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic signed [DATA_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [DATA_W-1:0] rsp_max_ff, rsp_max_in;
   logic [HELD_W-1:0]        rsp_held_ff, rsp_held_in;

   logic                     full;
   logic                     rd_en;
   logic [SLOT_W-1:0]        rd_addr;
   logic signed [DATA_W-1:0] rd_data;
   logic                     wr_en;
   logic                     div_start;
   div_sts_type              div_sts;
   logic signed [DATA_W-1:0] div_quot;
   logic signed [SUM_W-1:0]  old_ext;

   assign full = (fill_ff == FILL_W'(WINDOW));

   swts_ring #(
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   swts_div #(
      .SUM_W  (SUM_W),
      .FILL_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (fill_in),
      .sts      (div_sts),
      .quotient (div_quot)
   );

   // Sequence one request: fetch oldest, update ring and sum, scan, collect mean
   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      scan_idx_in  = scan_idx_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      first_in     = first_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mean_in  = rsp_mean_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_held_in  = rsp_held_ff;
      rd_en        = 1'b0;
      rd_addr      = slot_ff;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      old_ext      = full ? SUM_W'(rd_data) : '0;

      case (state_ff)
         S_IDLE: begin
            // Take the request and read the sample it displaces
            if (req_valid) begin
               sample_in = req_sample;
               rd_en     = full;
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // Drop the oldest sample, store the new one, start the divide
            sum_in      = sum_ff - old_ext + SUM_W'(sample_ff);
            fill_in     = full ? fill_ff : fill_ff + 1'b1;
            slot_in     = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            wr_en       = 1'b1;
            div_start   = 1'b1;
            scan_idx_in = '0;
            issue_in    = 1'b1;
            first_in    = 1'b1;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            // Issue one read a cycle over the held slots
            if (issue_ff) begin
               rd_en      = 1'b1;
               rd_addr    = scan_idx_ff;
               cmp_vld_in = 1'b1;
               if (FILL_W'(scan_idx_ff) + 1'b1 == fill_ff) begin
                  issue_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
            // Fold returned data into min and max
            if (cmp_vld_ff) begin
               first_in = 1'b0;
               if (first_ff || rd_data < lo_ff) begin
                  lo_in = rd_data;
               end
               if (first_ff || rd_data > hi_ff) begin
                  hi_in = rd_data;
               end
            end
            if (!issue_ff && !cmp_vld_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Hold until the divider is done and the response slot is free
            if (div_sts.done && !div_sts.busy && (!rsp_valid_ff || !rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = div_quot;
               rsp_min_in   = lo_ff;
               rsp_max_in   = hi_ff;
               rsp_held_in  = HELD_W'(fill_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         issue_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      scan_idx_ff <= scan_idx_in;
      first_ff    <= first_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_held_ff <= rsp_held_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_mean    = rsp_mean_ff;
   assign rsp_minimum = rsp_min_ff;
   assign rsp_maximum = rsp_max_ff;
   assign rsp_held    = rsp_held_ff;

endmodule

`default_nettype wire

[design/swts_ring.sv]
// Sample ring: one write port, one read port, registered read data.
// Depends on swts_pkg.
`default_nettype none

module swts_ring #(
   parameter  int DEPTH  = swts_pkg::WINDOW_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [ADDR_W-1:0]                 wr_addr,
   input  wire logic signed [swts_pkg::DATA_W-1:0] wr_data,
   input  wire logic                              rd_en,
   input  wire logic [ADDR_W-1:0]                 rd_addr,
   output logic signed [swts_pkg::DATA_W-1:0]     rd_data
);
   import swts_pkg::*;

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // Write the new sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/swts_div.sv]
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero.
// Depends on swts_pkg.
`default_nettype none

module swts_div #(
   parameter int SUM_W  = 20,
   parameter int FILL_W = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [SUM_W-1:0]       dividend,
   input  wire logic [FILL_W-1:0]             divisor,
   output swts_pkg::div_sts_type              sts,
   output logic signed [swts_pkg::DATA_W-1:0] quotient
);
   import swts_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [FILL_W:0]   rem_ff, rem_in;
   logic [FILL_W-1:0] dvs_ff, dvs_in;

   logic [FILL_W:0]   rem_sh;
   logic [FILL_W:0]   rem_diff;
   logic              fits;
   logic [SUM_W-1:0]  quo_signed;

   // Shift one dividend bit into the remainder and try a subtract
   always_comb begin
      rem_sh   = {rem_ff[FILL_W-1:0], quo_ff[SUM_W-1]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      fits     = (rem_sh >= {1'b0, dvs_ff});
   end

   // Sequence the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? rem_diff : rem_sh;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // Restore the sign of the quotient
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = quo_signed[DATA_W-1:0];
   assign sts.busy   = busy_ff;
   assign sts.done   = done_ff;

endmodule

`default_nettype wire

[design/swts_checker.sv]
// Port-level checks for the sliding-window temperature statistics block, bound to the top.
// Depends on swts_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module swts_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [swts_pkg::DATA_W-1:0] rsp_mean,
   input wire logic signed [swts_pkg::DATA_W-1:0] rsp_minimum,
   input wire logic signed [swts_pkg::DATA_W-1:0] rsp_maximum,
   input wire logic [swts_pkg::HELD_W-1:0]       rsp_held
);
   import swts_pkg::*;

   // Window minimum never exceeds window maximum
   `ASSERT_NEVER(a_min_le_max, clock, reset, rsp_valid && (rsp_minimum > rsp_maximum), "minimum above maximum")

   // Mean lies within the window range
   `ASSERT_PROP(a_mean_in_range, clock, reset, rsp_valid |-> (rsp_mean >= rsp_minimum && rsp_mean <= rsp_maximum), "mean outside window range")

   // One request in flight: stall right after a request is taken
   `ASSERT_PROP(a_one_in_flight, clock, reset, (req_valid && !req_stall) |=> req_stall, "second request taken while busy")

   // A stalled response holds its payload
   `ASSERT_PROP(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mean) && $stable(rsp_minimum) && $stable(rsp_maximum) && $stable(rsp_held)), "stalled response changed")

endmodule

bind sliding_window_temperature_stats swts_checker u_swts_checker (.*);

`default_nettype wire

[verif/tb_sliding_window_temperature_stats.sv]
// Self-checking testbench for sliding_window_temperature_stats: random and directed samples,
// a window predictor and a field-by-field result check. Depends on swts_pkg and the block RTL.
module tb_sliding_window_temperature_stats;
   timeunit 1ns;
   timeprecision 1ps;
   import swts_pkg::*;

   localparam int WINDOW     = WINDOW_DEF;
   localparam int TAIL_WAIT  = 60;
   localparam int HOLD_LEN   = 400;
   localparam int HOLD_AFTER = 1100;
   localparam int PHASE_LEN  = 460;

   typedef struct {
      logic signed [DATA_W-1:0] mean;
      logic signed [DATA_W-1:0] minimum;
      logic signed [DATA_W-1:0] maximum;
      logic [HELD_W-1:0]        held;
   } window_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DATA_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_mean;
   logic signed [DATA_W-1:0] rsp_minimum;
   logic signed [DATA_W-1:0] rsp_maximum;
   logic [HELD_W-1:0] rsp_held;

   // Predictor state: sample ring, next slot, fill count and exact sum
   int     win_ring [WINDOW];
   int     win_slot = 0;
   int     win_fill = 0;
   longint win_sum = 0;

   logic signed [DATA_W-1:0] pending_samples[$];
   window_stats_type         stats_expected[$];
   int  samples_taken = 0;
   int  error_count = 0;
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   logic long_hold = 1'b0;
   int  temp_level = 5120;

   sliding_window_temperature_stats #(.WINDOW(WINDOW)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_mean    (rsp_mean),
      .rsp_minimum (rsp_minimum),
      .rsp_maximum (rsp_maximum),
      .rsp_held    (rsp_held)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Append one sample to the pending queue
   function automatic void queue_sample(logic signed [DATA_W-1:0] sample);
      pending_samples.insert(pending_samples.size(), sample);
   endfunction

   // Insert one sample into the window and queue the statistics it yields
   function automatic void predict_window(logic signed [DATA_W-1:0] sample);
      window_stats_type st;
      int lo;
      int hi;
      if (win_fill >= WINDOW) begin
         win_sum -= win_ring[win_slot];
      end else begin
         win_fill++;
      end
      win_ring[win_slot] = sample;
      win_sum += sample;
      win_slot = (win_slot + 1 >= WINDOW) ? 0 : win_slot + 1;
      lo = win_ring[0];
      hi = win_ring[0];
      for (int i = 1; i < win_fill; i++) begin
         if (win_ring[i] < lo) lo = win_ring[i];
         if (win_ring[i] > hi) hi = win_ring[i];
      end
      // signed division truncates toward zero
      st.mean    = DATA_W'(win_sum / longint'(win_fill));
      st.minimum = DATA_W'(lo);
      st.maximum = DATA_W'(hi);
      st.held    = HELD_W'(win_fill);
      stats_expected.insert(stats_expected.size(), st);
   endfunction

   // Draw a sample: often full range, some slow drift, some extremes
   function automatic logic signed [DATA_W-1:0] next_sample();
      int pick;
      int v;
      pick = $urandom_range(99);
      if (pick < 45) begin
         v = $signed(DATA_W'($urandom));
      end else if (pick < 80) begin
         temp_level += $urandom_range(64) - 32;
         if (temp_level > 32767) temp_level = 32767;
         if (temp_level < -32768) temp_level = -32768;
         v = temp_level;
      end else if (pick < 90) begin
         case ($urandom_range(4))
            0: v = 32767;
            1: v = -32768;
            2: v = -1;
            3: v = 0;
            default: v = 1;
         endcase
      end else if (pick < 95) begin
         v = 32767 - $urandom_range(255);
      end else begin
         v = -32768 + $urandom_range(255);
      end
      return DATA_W'(v);
   endfunction

   task automatic report_error(string what, int got, int want);
      error_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Drive requests from the pending queue; hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            predict_window(req_sample);
            pending_samples.delete(0);
            samples_taken++;
         end
         if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_valid  <= 1'b1;
            req_sample <= pending_samples[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side at random, or hard during the long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= long_hold || ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stats_expected.size() == 0) begin
            report_error("result with nothing pending, mean", rsp_mean, 0);
         end else begin
            if (rsp_mean !== stats_expected[0].mean)
               report_error("mean", rsp_mean, stats_expected[0].mean);
            if (rsp_minimum !== stats_expected[0].minimum)
               report_error("minimum", rsp_minimum, stats_expected[0].minimum);
            if (rsp_maximum !== stats_expected[0].maximum)
               report_error("maximum", rsp_maximum, stats_expected[0].maximum);
            if (rsp_held !== stats_expected[0].held)
               report_error("held", rsp_held, stats_expected[0].held);
            stats_expected.delete(0);
         end
      end
   end

   // Hold off the result side for a long stretch so the block backs up
   initial begin
      while (samples_taken < HOLD_AFTER) @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("tb_sliding_window_temperature_stats: errors");
      $finish;
   end

   // Stimulus: directed window cases, then three phases of random samples with different idle rates
   initial begin
      while (reset) @(posedge clock);
      // fill with the most negative value, then with the most positive
      repeat (WINDOW) queue_sample(-16'sd32768);
      repeat (WINDOW) queue_sample(16'sd32767);
      queue_sample(-16'sd1);
      queue_sample(16'sd1);
      queue_sample(16'sd0);
      queue_sample(16'sh5555);
      queue_sample(16'shAAAA);
      for (int phase = 0; phase < 3; phase++) begin
         while (pending_samples.size() != 0 || stats_expected.size() != 0) @(posedge clock);
         @(posedge clock);
         case (phase)
            0: begin
               tx_idle_pct <= 36;
               rx_idle_pct <= 81;
            end
            1: begin
               tx_idle_pct <= 81;
               rx_idle_pct <= 36;
            end
            default: begin
               tx_idle_pct <= 0;
               rx_idle_pct <= 0;
            end
         endcase
         for (int i = 0; i < PHASE_LEN; i++) queue_sample(next_sample());
      end
      // drain and let the block settle
      while (pending_samples.size() != 0 || stats_expected.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (stats_expected.size() != 0)
         report_error("results left pending", stats_expected.size(), 0);
      if (error_count == 0) begin
         $display("tb_sliding_window_temperature_stats: clean");
      end else begin
         $display("tb_sliding_window_temperature_stats: errors");
      end
      $finish;
   end

endmodule
